/* hw/rtl/ac3_eac3_sync_header_parser_assert.svh */
// assertion macros for the ac3 / e-ac3 sync header parser
`ifndef AC3_EAC3_SYNC_HEADER_PARSER_ASSERT_SVH
`define AC3_EAC3_SYNC_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define AC3P_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AC3P_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ac3p_pkg.sv */
// constants and lookup tables for the ac3 / e-ac3 sync header parser
package ac3p_pkg;

	localparam logic [7:0] SYNC_HI = 8'h0B;
	localparam logic [7:0] SYNC_LO = 8'h77;
	localparam logic [4:0] BSID_AC3_MAX = 5'd10;
	localparam logic [4:0] BSID_EAC3_MAX = 5'd16;
	localparam logic [5:0] SIZE_CODE_LIMIT = 6'd38;
	localparam logic [1:0] FSCOD_RESERVED = 2'd3;
	localparam int DIV_BITS = 23;
	localparam int IN_DATA_BITS = 8;
	localparam int OUT_DATA_BITS = 128;
	// ceil(2^25 / 3), exact for dividends below 2^25
	localparam logic [23:0] RECIP_3 = 24'hAAAAAB;

	// nominal ac3 bit rate in kbit/s per frmsizecod pair
	function automatic logic [9:0] ac3_kbps(input logic [4:0] idx);
		logic [9:0] v;
		unique case (idx)
			5'd0: v = 10'd32;
			5'd1: v = 10'd40;
			5'd2: v = 10'd48;
			5'd3: v = 10'd56;
			5'd4: v = 10'd64;
			5'd5: v = 10'd80;
			5'd6: v = 10'd96;
			5'd7: v = 10'd112;
			5'd8: v = 10'd128;
			5'd9: v = 10'd160;
			5'd10: v = 10'd192;
			5'd11: v = 10'd224;
			5'd12: v = 10'd256;
			5'd13: v = 10'd320;
			5'd14: v = 10'd384;
			5'd15: v = 10'd448;
			5'd16: v = 10'd512;
			5'd17: v = 10'd576;
			5'd18: v = 10'd640;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

	// ac3 frame words at 44.1 khz for even frmsizecod; odd codes add one
	function automatic logic [10:0] ac3_words_44k(input logic [4:0] idx);
		logic [10:0] v;
		unique case (idx)
			5'd0: v = 11'd69;
			5'd1: v = 11'd87;
			5'd2: v = 11'd104;
			5'd3: v = 11'd121;
			5'd4: v = 11'd139;
			5'd5: v = 11'd174;
			5'd6: v = 11'd208;
			5'd7: v = 11'd243;
			5'd8: v = 11'd278;
			5'd9: v = 11'd348;
			5'd10: v = 11'd417;
			5'd11: v = 11'd487;
			5'd12: v = 11'd557;
			5'd13: v = 11'd696;
			5'd14: v = 11'd835;
			5'd15: v = 11'd975;
			5'd16: v = 11'd1114;
			5'd17: v = 11'd1253;
			5'd18: v = 11'd1393;
			default: v = 11'd0;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rate_full(input logic [1:0] code);
		logic [15:0] v;
		unique case (code)
			2'd0: v = 16'd48000;
			2'd1: v = 16'd44100;
			2'd2: v = 16'd32000;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rate_half(input logic [1:0] code);
		logic [15:0] v;
		unique case (code)
			2'd0: v = 16'd24000;
			2'd1: v = 16'd22050;
			2'd2: v = 16'd16000;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] block_count(input logic [1:0] code);
		logic [2:0] v;
		unique case (code)
			2'd0: v = 3'd1;
			2'd1: v = 3'd2;
			2'd2: v = 3'd3;
			default: v = 3'd6;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/ac3_eac3_sync_header_parser.sv */
// ac3 / e-ac3 sync frame header parser top level
// usage:
//   s_axis carries one stream byte per word in tdata; tuser set marks the first
//   byte of a new buffer and clears the scan and the byte position first.
//   m_axis gives one word per valid header, on the word after its last byte;
//   tuser is the stream kind (0 ac3, 1 e-ac3), tdata the decoded fields.
// throughput and decode:
//   ordinary bytes take one cycle each. after the last header byte, tready
//   stays low while the header is decoded: the multiply step alone for a
//   rejected header, then the output step for ac3, or the divide and output
//   steps for e-ac3, where one shared multiplier forms frame bytes times sample
//   rate and then divides by the block count as a halving and a multiply by the
//   reciprocal of three. the result word is valid on the cycle after that.
// reset:
//   arst_n clears the scan, the byte position and the output valid.
// stall:
//   the result sits in an output register; bytes keep flowing while it waits.
//   a later header that is done before the word is taken holds tready low
//   until m_axis_tready frees the output register.
`include "ac3_eac3_sync_header_parser_assert.svh"

module ac3_eac3_sync_header_parser #(
	parameter int POSITION_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [7:0] data_byte
	input  logic [ac3p_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
	// [0] restart
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [4:0] bsid_value, [20:5] crc_word, [36:21] sample_rate, [49:37] frame_bytes,
	// [72:50] bit_rate, [75:73] audio_blocks, [107:76] start_position,
	// [109:108] stream_type, [112:110] substream_id, [114:113] rate_code,
	// [120:115] size_code, [127:121] zero
	output logic [ac3p_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
	// [0] stream_kind
	output logic                                m_axis_tuser
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_HDR0 = 3'd2;
	localparam logic [2:0] PH_HDR3 = 3'd5;

	localparam logic [1:0] ST_SCAN = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	localparam logic [POSITION_BITS-1:0] HDR_OFFSET = POSITION_BITS'(5);

	logic [1:0] state_q;
	logic [2:0] phase_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [7:0] hdr_q [4];
	logic [ac3p_pkg::DIV_BITS-1:0] dq_q;
	logic m_valid_q;
	logic [ac3p_pkg::OUT_DATA_BITS-1:0] m_data_q;
	logic m_kind_q;

	logic s_accept;
	logic [7:0] in_byte;
	logic [2:0] phase_eff;
	logic [POSITION_BITS-1:0] pos_cur;
	logic [1:0] hdr_idx;

	logic [4:0] bsid;
	logic [1:0] fscod;
	logic [5:0] fsc;
	logic [1:0] code54;
	logic is_ac3;
	logic is_eac3;
	logic ac3_bad;
	logic [9:0] kbps;
	logic [11:0] ac3_words;
	logic [22:0] ac3_rate;
	logic [10:0] frmsiz;
	logic [12:0] eac3_bytes;
	logic [1:0] nb_code;
	logic [2:0] blocks;
	logic [15:0] srate;
	logic [12:0] fbytes;
	logic [22:0] div_in;
	logic [22:0] mul_a;
	logic [23:0] mul_b;
	logic [46:0] product;
	logic [15:0] crc;
	logic [22:0] brate;
	logic [1:0] styp;
	logic [2:0] sub;
	logic [5:0] size_code;
	logic [POSITION_BITS+31:0] start_wide;
	logic [31:0] start32;

	assign s_axis_tready = (state_q == ST_SCAN);
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign in_byte = s_axis_tdata[7:0];
	assign phase_eff = s_axis_tuser ? PH_HUNT : phase_q;
	assign pos_cur = s_axis_tuser ? '0 : pos_q;
	assign hdr_idx = 2'(phase_eff - PH_HDR0);

	always_comb begin
		bsid = hdr_q[3][7:3];
		fscod = hdr_q[2][7:6];
		fsc = hdr_q[2][5:0];
		code54 = hdr_q[2][5:4];
		is_ac3 = (bsid <= ac3p_pkg::BSID_AC3_MAX);
		is_eac3 = !is_ac3 && (bsid <= ac3p_pkg::BSID_EAC3_MAX);
		ac3_bad = (fscod == ac3p_pkg::FSCOD_RESERVED) || (fsc >= ac3p_pkg::SIZE_CODE_LIMIT);
		kbps = ac3p_pkg::ac3_kbps(fsc[5:1]);
		unique case (fscod)
			2'd0: ac3_words = {1'b0, kbps, 1'b0};
			2'd1: ac3_words = 12'(ac3p_pkg::ac3_words_44k(fsc[5:1])) + 12'(fsc[0]);
			2'd2: ac3_words = 12'(kbps) + {1'b0, kbps, 1'b0};
			default: ac3_words = '0;
		endcase
		ac3_rate = 23'(kbps) * 23'd1000;
		frmsiz = {hdr_q[0][2:0], hdr_q[1]};
		eac3_bytes = {12'(frmsiz) + 12'd1, 1'b0};
		if (fscod == ac3p_pkg::FSCOD_RESERVED && !is_ac3) begin
			srate = ac3p_pkg::rate_half(code54);
			nb_code = 2'd3;
		end else begin
			srate = ac3p_pkg::rate_full(fscod);
			nb_code = is_ac3 ? 2'd3 : code54;
		end
		blocks = ac3p_pkg::block_count(nb_code);
		fbytes = is_ac3 ? {ac3_words, 1'b0} : eac3_bytes;
		// block counts 2 and 6 halve first, 3 and 6 then divide by three
		div_in = nb_code[0] ? {1'b0, dq_q[ac3p_pkg::DIV_BITS-1:1]} : dq_q;
		mul_a = (state_q == ST_DIV) ? div_in : 23'(fbytes);
		mul_b = (state_q == ST_DIV) ? ac3p_pkg::RECIP_3 : 24'(srate);
		product = 47'(mul_a) * 47'(mul_b);
		crc = is_ac3 ? {hdr_q[0], hdr_q[1]} : 16'd0;
		brate = is_ac3 ? ac3_rate : dq_q;
		styp = is_ac3 ? 2'd0 : hdr_q[0][7:6];
		sub = is_ac3 ? 3'd0 : hdr_q[0][5:3];
		size_code = is_ac3 ? fsc : 6'd0;
		start_wide = {32'd0, start_q};
		start32 = start_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
			phase_q <= PH_HUNT;
			pos_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SCAN: begin
					if (s_accept) begin
						pos_q <= pos_cur + POSITION_BITS'(1);
						priority if (phase_eff == PH_HUNT) begin
							phase_q <= (in_byte == ac3p_pkg::SYNC_HI) ? PH_SECOND : PH_HUNT;
						end else if (phase_eff == PH_SECOND) begin
							priority if (in_byte == ac3p_pkg::SYNC_LO) begin
								phase_q <= PH_HDR0;
							end else if (in_byte != ac3p_pkg::SYNC_HI) begin
								phase_q <= PH_HUNT;
							end else begin
								phase_q <= PH_SECOND;
							end
						end else if (phase_eff > PH_HDR3) begin
							phase_q <= PH_HUNT;
						end else if (phase_eff < PH_HDR3) begin
							phase_q <= phase_eff + 3'd1;
						end else begin
							phase_q <= PH_HUNT;
							start_q <= pos_cur - HDR_OFFSET;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					priority if (is_ac3) begin
						state_q <= ac3_bad ? ST_SCAN : ST_OUT;
					end else if (is_eac3) begin
						dq_q <= product[27:5];
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_DIV: begin
					dq_q <= nb_code[1] ? 23'(product[46:25]) : div_in;
					state_q <= ST_OUT;
				end
				default: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && phase_eff >= PH_HDR0 && phase_eff <= PH_HDR3) begin
			hdr_q[hdr_idx] <= in_byte;
		end
		if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
			m_kind_q <= !is_ac3;
			m_data_q <= {7'd0, size_code, fscod, sub, styp, start32, blocks, brate,
				fbytes, srate, crc, bsid};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_kind_q;

	`AC3P_ASSERT_IMP(a_out_from_final, clk, arst_n, $rose(m_valid_q),
		$past(state_q) == ST_OUT, "result word raised outside the output step")
	`AC3P_ASSERT_IMP(a_div_eac3_only, clk, arst_n, state_q == ST_DIV,
		is_eac3, "divide step entered for a header that is not e-ac3")
	`AC3P_ASSERT_NXT(a_last_byte_decodes, clk, arst_n, s_accept && phase_eff == PH_HDR3,
		state_q == ST_MUL, "last header byte did not start the decode")
	`AC3P_ASSERT_NXT(a_div_one_step, clk, arst_n, state_q == ST_DIV,
		state_q == ST_OUT, "divide step did not lead to the output step")

endmodule

/* tb/sv/ac3_eac3_sync_header_parser_tb.sv */
// testbench for the ac3 / e-ac3 sync header parser: byte stream in, decoded headers checked
module ac3_eac3_sync_header_parser_tb;

	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PCT = 14;
	localparam int RANDOM_BYTES = 470;

	typedef enum logic [2:0] {
		SCAN_HUNT,
		SCAN_SYNC2,
		SCAN_HDR0,
		SCAN_HDR1,
		SCAN_HDR2,
		SCAN_HDR3
	} scan_e;

	// m_axis_tdata layout, lowest field last
	typedef struct packed {
		logic [6:0] pad;
		logic [5:0] size_code;
		logic [1:0] rate_code;
		logic [2:0] substream_id;
		logic [1:0] stream_type;
		logic [31:0] start_position;
		logic [2:0] audio_blocks;
		logic [22:0] bit_rate;
		logic [12:0] frame_bytes;
		logic [15:0] sample_rate;
		logic [15:0] crc_word;
		logic [4:0] bsid_value;
	} fields_t;

	typedef struct {
		logic kind;
		fields_t f;
	} header_t;

	typedef struct {
		logic [7:0] data;
		logic restart;
	} stim_t;

	localparam int KBPS_TAB [19] = '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
		192, 224, 256, 320, 384, 448, 512, 576, 640};
	localparam int FULL_RATE [4] = '{48000, 44100, 32000, 0};
	localparam int HALF_RATE [4] = '{24000, 22050, 16000, 0};
	localparam int BLOCKS_TAB [4] = '{1, 2, 3, 6};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ac3p_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [ac3p_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
	logic m_axis_tuser;

	stim_t byte_q [$];
	header_t pending_headers [$];
	stim_t next_in;
	header_t want;
	fields_t got;
	scan_e scan = SCAN_HUNT;
	logic [7:0] hdr [4];
	logic [31:0] pos = '0;
	int restart_pct = 0;
	int in_count = 0;
	int stall_cycles = 0;
	int errors = 0;
	int directed_n;
	bit in_taken = 1'b0;

	ac3_eac3_sync_header_parser #(
		.POSITION_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit decode_sync_header(input logic [31:0] start, output header_t r);
		logic [4:0] bsid;
		logic [1:0] fscod;
		logic [5:0] fsc;
		logic [1:0] nb;
		longint kbps, words, fb, rate, blocks;
		bsid = hdr[3][7:3];
		fscod = hdr[2][7:6];
		fsc = hdr[2][5:0];
		r.kind = 1'b0;
		r.f = '0;
		if (bsid <= ac3p_pkg::BSID_AC3_MAX) begin
			if (fscod == ac3p_pkg::FSCOD_RESERVED || fsc >= ac3p_pkg::SIZE_CODE_LIMIT)
				return 1'b0;
			kbps = KBPS_TAB[fsc[5:1]];
			case (fscod)
				2'd0: words = kbps * 2;
				2'd1: words = kbps * 320 / 147 + fsc[0];
				default: words = kbps * 3;
			endcase
			r.f.crc_word = {hdr[0], hdr[1]};
			r.f.sample_rate = 16'(FULL_RATE[fscod]);
			r.f.frame_bytes = 13'(words * 2);
			r.f.bit_rate = 23'(kbps * 1000);
			r.f.audio_blocks = 3'd6;
			r.f.size_code = fsc;
		end else if (bsid <= ac3p_pkg::BSID_EAC3_MAX) begin
			r.kind = 1'b1;
			r.f.stream_type = hdr[0][7:6];
			r.f.substream_id = hdr[0][5:3];
			fb = ({hdr[0][2:0], hdr[1]} + 1) * 2;
			if (fscod == ac3p_pkg::FSCOD_RESERVED) begin
				rate = HALF_RATE[hdr[2][5:4]];
				nb = 2'd3;
			end else begin
				rate = FULL_RATE[fscod];
				nb = hdr[2][5:4];
			end
			blocks = BLOCKS_TAB[nb];
			r.f.sample_rate = 16'(rate);
			r.f.frame_bytes = 13'(fb);
			r.f.bit_rate = 23'((8 * fb * rate) / (blocks * 256));
			r.f.audio_blocks = 3'(blocks);
		end else begin
			return 1'b0;
		end
		r.f.bsid_value = bsid;
		r.f.start_position = start;
		r.f.rate_code = fscod;
		return 1'b1;
	endfunction

	task automatic scan_byte(input logic [7:0] b, input logic rs);
		logic [31:0] here;
		header_t r;
		if (rs) begin
			scan = SCAN_HUNT;
			pos = '0;
		end
		here = pos;
		pos = pos + 32'd1;
		case (scan)
			SCAN_HUNT: begin
				if (b == ac3p_pkg::SYNC_HI)
					scan = SCAN_SYNC2;
			end
			SCAN_SYNC2: begin
				if (b == ac3p_pkg::SYNC_LO)
					scan = SCAN_HDR0;
				else if (b != ac3p_pkg::SYNC_HI)
					scan = SCAN_HUNT;
			end
			default: begin
				hdr[scan - SCAN_HDR0] = b;
				if (scan != SCAN_HDR3) begin
					scan = scan_e'(scan + 3'd1);
				end else begin
					scan = SCAN_HUNT;
					if (decode_sync_header(here - 32'd5, r))
						pending_headers.push_back(r);
				end
			end
		endcase
	endtask

	task automatic check_field(input string what, input longint unsigned exp_v,
			input longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, what, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit rs);
		stim_t s;
		s.data = b;
		s.restart = rs || ($urandom_range(99) < restart_pct);
		byte_q.push_back(s);
	endtask

	task automatic queue_header(input logic [31:0] h, input bit rs);
		queue_byte(ac3p_pkg::SYNC_HI, rs);
		queue_byte(ac3p_pkg::SYNC_LO, 1'b0);
		queue_byte(h[31:24], 1'b0);
		queue_byte(h[23:16], 1'b0);
		queue_byte(h[15:8], 1'b0);
		queue_byte(h[7:0], 1'b0);
	endtask

	function automatic logic [31:0] ac3_header(input int bsid, input int fscod, input int fsc,
			input logic [15:0] crc);
		logic [7:0] b2, b3;
		b2 = {fscod[1:0], fsc[5:0]};
		b3 = {bsid[4:0], 3'($urandom_range(7))};
		return {crc, b2, b3};
	endfunction

	function automatic logic [31:0] eac3_header(input int bsid, input int styp, input int sub,
			input int frmsiz, input int fscod, input int code2);
		logic [7:0] b0, b1, b2, b3;
		b0 = {styp[1:0], sub[2:0], frmsiz[10:8]};
		b1 = frmsiz[7:0];
		b2 = {fscod[1:0], code2[1:0], 4'($urandom_range(15))};
		b3 = {bsid[4:0], 3'($urandom_range(7))};
		return {b0, b1, b2, b3};
	endfunction

	task automatic queue_random_header();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			queue_header({16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
				5'($urandom_range(17, 31)), 3'($urandom_range(7))}, 1'b0);
		else if (pick <= 5)
			queue_header(ac3_header($urandom_range(10),
				($urandom_range(9) == 0) ? 3 : $urandom_range(2),
				($urandom_range(9) == 0) ? $urandom_range(38, 63) : $urandom_range(37),
				16'($urandom_range(16'hFFFF))), 1'b0);
		else
			queue_header(eac3_header($urandom_range(11, 16), $urandom_range(3),
				$urandom_range(7), $urandom_range(2047), $urandom_range(3),
				$urandom_range(3)), 1'b0);
	endtask

	function automatic bit steady();
		return in_count >= 200 && in_count < 350;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken || !s_axis_tvalid) begin
				in_taken = 1'b0;
				if (byte_q.size() != 0 && (steady() || $urandom_range(99) >= IDLE_PCT)) begin
					next_in = byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_in.data;
					s_axis_tuser <= next_in.restart;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= steady() || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor, predictor feed and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_headers.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time,
						m_axis_tdata);
					errors++;
				end else begin
					want = pending_headers.pop_front();
					got = fields_t'(m_axis_tdata);
					check_field("stream_kind", want.kind, m_axis_tuser);
					check_field("bsid_value", want.f.bsid_value, got.bsid_value);
					check_field("crc_word", want.f.crc_word, got.crc_word);
					check_field("sample_rate", want.f.sample_rate, got.sample_rate);
					check_field("frame_bytes", want.f.frame_bytes, got.frame_bytes);
					check_field("bit_rate", want.f.bit_rate, got.bit_rate);
					check_field("audio_blocks", want.f.audio_blocks, got.audio_blocks);
					check_field("start_position", want.f.start_position, got.start_position);
					check_field("stream_type", want.f.stream_type, got.stream_type);
					check_field("substream_id", want.f.substream_id, got.substream_id);
					check_field("rate_code", want.f.rate_code, got.rate_code);
					check_field("size_code", want.f.size_code, got.size_code);
					check_field("pad", want.f.pad, got.pad);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				scan_byte(s_axis_tdata, s_axis_tuser);
				in_taken = 1'b1;
				in_count++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t timeout, %0d results outstanding", $time, pending_headers.size());
				$display("[ac3_eac3_sync_header_parser] ERROR");
				$finish;
			end
		end
	end

	initial begin
		// ac3 table corners, both crc extremes and a crc that looks like sync
		queue_header(ac3_header(8, 0, 0, 16'h0000), 1'b1);
		queue_header(ac3_header(0, 1, 37, 16'hFFFF), 1'b0);
		queue_header(ac3_header(10, 2, 36, {ac3p_pkg::SYNC_HI, ac3p_pkg::SYNC_LO}), 1'b0);
		queue_header(ac3_header(6, 1, 1, 16'h5AA5), 1'b0);
		// reserved fscod, size code out of range, bsid out of range
		queue_header(ac3_header(4, 3, 10, 16'h1234), 1'b0);
		queue_header(ac3_header(4, 0, 38, 16'h1234), 1'b0);
		queue_header(ac3_header(4, 2, 63, 16'h1234), 1'b0);
		queue_header(ac3_header(17, 0, 4, 16'h1234), 1'b0);
		queue_header(ac3_header(31, 0, 4, 16'h1234), 1'b0);
		// e-ac3 extremes and the half-rate codes
		queue_header(eac3_header(11, 3, 7, 2047, 0, 3), 1'b0);
		queue_header(eac3_header(16, 0, 0, 0, 1, 0), 1'b0);
		for (int c = 0; c < 4; c++)
			queue_header(eac3_header(16, c, c, 100 + c, 3, c), 1'b0);
		queue_header(eac3_header(12, 1, 2, $urandom_range(2047), 2, 1), 1'b0);
		// repeated first sync byte
		queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
		queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
		queue_header(ac3_header(3, 0, 20, 16'hBEEF), 1'b0);
		// broken sync, then a stray second sync byte while hunting
		queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
		queue_byte(8'h12, 1'b0);
		queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(ac3p_pkg::SYNC_LO, 1'b0);
		// rejected header whose body holds a sync word must not be rescanned
		queue_header({ac3p_pkg::SYNC_HI, ac3p_pkg::SYNC_LO, 8'hC0, 8'h40}, 1'b0);
		queue_byte(8'h10, 1'b0);
		queue_byte(8'h40, 1'b0);
		// restart inside a header and between the two sync bytes
		queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
		queue_byte(ac3p_pkg::SYNC_LO, 1'b0);
		queue_byte(8'hA5, 1'b0);
		queue_header(eac3_header(14, 2, 5, 777, 0, 2), 1'b1);
		queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
		queue_byte(ac3p_pkg::SYNC_LO, 1'b1);
		queue_header(ac3_header(9, 1, 12, 16'h0F0F), 1'b0);
		directed_n = byte_q.size();

		restart_pct = 2;
		while (byte_q.size() < directed_n + RANDOM_BYTES) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5, 6: begin
					repeat ($urandom_range(2))
						queue_byte(8'($urandom_range(255)), 1'b0);
					queue_random_header();
				end
				7: begin
					repeat ($urandom_range(1, 3))
						queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
					queue_random_header();
				end
				8: begin
					queue_byte(ac3p_pkg::SYNC_HI, 1'b0);
					if ($urandom_range(1))
						queue_byte(ac3p_pkg::SYNC_LO, 1'b0);
					repeat ($urandom_range(1, 4))
						queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
				end
				default: begin
					repeat ($urandom_range(1, 8))
						queue_byte(8'($urandom_range(255)), 1'b0);
				end
			endcase
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (byte_q.size() != 0 || s_axis_tvalid || pending_headers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ac3_eac3_sync_header_parser] OK");
		else
			$display("[ac3_eac3_sync_header_parser] ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ac3p_pkg.sv
hw/rtl/ac3_eac3_sync_header_parser.sv
tb/sv/ac3_eac3_sync_header_parser_tb.sv
